// ===== sv/mue_pkg.sv =====
// Morse unit encoder package: types, constants and the character table.
package mue_pkg;

   localparam int MAX_UNITS  = 256;
   localparam int UNIT_CNT_W = $clog2(MAX_UNITS + 1);
   localparam logic [UNIT_CNT_W-1:0] UNIT_CAP      = UNIT_CNT_W'(MAX_UNITS);
   localparam logic [UNIT_CNT_W-1:0] UNIT_CAP_LAST = UNIT_CNT_W'(MAX_UNITS - 1);

   localparam int SYM_MAX   = 5;
   localparam int SYM_CNT_W = $clog2(SYM_MAX + 1);
   localparam int RUN_W     = 2;

   // units still to go in a phase after the current one
   localparam logic [RUN_W-1:0] DASH_EXTRA = 2'd2;
   localparam logic [RUN_W-1:0] GAP_EXTRA  = 2'd1;
   localparam logic [RUN_W-1:0] FOUR_EXTRA = 2'd3;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ON,
      ST_OFF,
      ST_GAP,
      ST_PAUSE
   } mue_state_type;

   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_SPACE,
      KIND_SYMBOL
   } mue_kind_type;

   typedef enum logic [2:0] {
      RUN_HOLD,
      RUN_DEC,
      RUN_SYM,
      RUN_GAP,
      RUN_FOUR
   } mue_run_op_type;

   // dashes: bit 0 is the first symbol, 1 = dash
   typedef struct packed {
      mue_kind_type         kind;
      logic [SYM_CNT_W-1:0] len;
      logic [SYM_MAX-1:0]   dashes;
   } mue_char_type;

   typedef struct packed {
      logic           load;
      logic           emit;
      logic           unit_on;
      logic           unit_last;
      logic           sym_next;
      mue_run_op_type run_op;
   } mue_cmd_type;

   typedef struct packed {
      mue_kind_type in_kind;
      logic         in_at_cap;
      logic         in_last;
      logic         run_zero;
      logic         more_syms;
      logic         pause;
      logic         cap_next;
      logic         out_free;
   } mue_status_type;

   function automatic mue_char_type sym_pat(logic [SYM_CNT_W-1:0] len,
                                            logic [SYM_MAX-1:0] dashes);
      mue_char_type res;
      res.kind   = KIND_SYMBOL;
      res.len    = len;
      res.dashes = dashes;
      return res;
   endfunction

   function automatic mue_char_type char_lookup(logic [7:0] ch);
      mue_char_type res;
      res.kind   = KIND_OTHER;
      res.len    = '0;
      res.dashes = '0;
      unique case (ch)
         CHAR_SPACE: res.kind = KIND_SPACE;
         8'h41: res = sym_pat(3'd2, 5'b00010); // A
         8'h42: res = sym_pat(3'd4, 5'b00001);
         8'h43: res = sym_pat(3'd4, 5'b00101);
         8'h44: res = sym_pat(3'd3, 5'b00001);
         8'h45: res = sym_pat(3'd1, 5'b00000);
         8'h46: res = sym_pat(3'd4, 5'b00100);
         8'h47: res = sym_pat(3'd3, 5'b00011);
         8'h48: res = sym_pat(3'd4, 5'b00000);
         8'h49: res = sym_pat(3'd2, 5'b00000);
         8'h4A: res = sym_pat(3'd4, 5'b01110);
         8'h4B: res = sym_pat(3'd3, 5'b00101);
         8'h4C: res = sym_pat(3'd4, 5'b00010);
         8'h4D: res = sym_pat(3'd2, 5'b00011);
         8'h4E: res = sym_pat(3'd2, 5'b00001);
         8'h4F: res = sym_pat(3'd3, 5'b00111);
         8'h50: res = sym_pat(3'd4, 5'b00110);
         8'h51: res = sym_pat(3'd4, 5'b01011);
         8'h52: res = sym_pat(3'd3, 5'b00010);
         8'h53: res = sym_pat(3'd3, 5'b00000);
         8'h54: res = sym_pat(3'd1, 5'b00001);
         8'h55: res = sym_pat(3'd3, 5'b00100);
         8'h56: res = sym_pat(3'd4, 5'b01000);
         8'h57: res = sym_pat(3'd3, 5'b00110);
         8'h58: res = sym_pat(3'd4, 5'b01001);
         8'h59: res = sym_pat(3'd4, 5'b01101);
         8'h5A: res = sym_pat(3'd4, 5'b00011); // Z
         8'h30: res = sym_pat(3'd5, 5'b11111); // 0
         8'h31: res = sym_pat(3'd5, 5'b11110);
         8'h32: res = sym_pat(3'd5, 5'b11100);
         8'h33: res = sym_pat(3'd5, 5'b11000);
         8'h34: res = sym_pat(3'd5, 5'b10000);
         8'h35: res = sym_pat(3'd5, 5'b00000);
         8'h36: res = sym_pat(3'd5, 5'b00001);
         8'h37: res = sym_pat(3'd5, 5'b00011);
         8'h38: res = sym_pat(3'd5, 5'b00111);
         8'h39: res = sym_pat(3'd5, 5'b01111); // 9
         default: res.kind = KIND_OTHER;
      endcase
      return res;
   endfunction

endpackage

// ===== sv/mue_chan_if.sv =====
// Valid/ready channel interfaces for message characters and Morse units.
interface mue_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       first_of_message;
   logic       last_of_message;

   modport source (output valid, output char_code, output first_of_message,
                   output last_of_message, input ready);
   modport sink (input valid, input char_code, input first_of_message,
                 input last_of_message, output ready);
endinterface

interface mue_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic unit_on;
   logic last_unit;

   modport source (output valid, output unit_on, output last_unit, input ready);
   modport sink (input valid, input unit_on, input last_unit, output ready);
endinterface

// ===== sv/mue_ctrl.sv =====
// Morse unit encoder controller: sequences symbol, gap and pause phases.
module mue_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mue_pkg::mue_status_type status,
   output mue_pkg::mue_cmd_type    cmd
);

   mue_pkg::mue_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mue_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mue_pkg::ST_IDLE: begin
            if (req_valid && !status.in_at_cap) begin
               unique case (status.in_kind)
                  mue_pkg::KIND_SYMBOL: state_in = mue_pkg::ST_ON;
                  mue_pkg::KIND_SPACE:  state_in = mue_pkg::ST_GAP;
                  default: state_in = status.in_last ? mue_pkg::ST_PAUSE : mue_pkg::ST_IDLE;
               endcase
            end
         end
         mue_pkg::ST_ON: begin
            if (status.out_free) begin
               priority if (status.cap_next) state_in = mue_pkg::ST_IDLE;
               else if (status.run_zero) state_in = mue_pkg::ST_OFF;
               else state_in = mue_pkg::ST_ON;
            end
         end
         mue_pkg::ST_OFF: begin
            if (status.out_free) begin
               priority if (status.cap_next) state_in = mue_pkg::ST_IDLE;
               else if (status.more_syms) state_in = mue_pkg::ST_ON;
               else state_in = mue_pkg::ST_GAP;
            end
         end
         mue_pkg::ST_GAP: begin
            if (status.out_free) begin
               priority if (status.cap_next) state_in = mue_pkg::ST_IDLE;
               else if (status.run_zero) begin
                  state_in = status.pause ? mue_pkg::ST_PAUSE : mue_pkg::ST_IDLE;
               end
               else state_in = mue_pkg::ST_GAP;
            end
         end
         mue_pkg::ST_PAUSE: begin
            if (status.out_free && (status.cap_next || status.run_zero)) begin
               state_in = mue_pkg::ST_IDLE;
            end
         end
         default: state_in = mue_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.emit      = 1'b0;
      cmd.unit_on   = 1'b0;
      cmd.unit_last = 1'b0;
      cmd.sym_next  = 1'b0;
      cmd.run_op    = mue_pkg::RUN_HOLD;
      unique case (state_ff)
         mue_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (status.in_kind)
                  mue_pkg::KIND_SYMBOL: cmd.run_op = mue_pkg::RUN_SYM;
                  default: cmd.run_op = mue_pkg::RUN_FOUR;
               endcase
            end
         end
         mue_pkg::ST_ON: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.unit_on   = 1'b1;
               cmd.unit_last = status.cap_next;
               cmd.run_op    = status.run_zero ? mue_pkg::RUN_HOLD : mue_pkg::RUN_DEC;
            end
         end
         mue_pkg::ST_OFF: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.unit_last = status.cap_next;
               cmd.sym_next  = 1'b1;
               cmd.run_op    = status.more_syms ? mue_pkg::RUN_SYM : mue_pkg::RUN_GAP;
            end
         end
         mue_pkg::ST_GAP: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.unit_last = status.cap_next || (status.run_zero && !status.pause);
               cmd.run_op    = status.run_zero ? mue_pkg::RUN_FOUR : mue_pkg::RUN_DEC;
            end
         end
         mue_pkg::ST_PAUSE: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.unit_last = status.cap_next || status.run_zero;
               cmd.run_op    = status.run_zero ? mue_pkg::RUN_HOLD : mue_pkg::RUN_DEC;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/mue_datapath.sv =====
// Morse unit encoder datapath: pattern, phase and unit counters, output register.
module mue_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mue_pkg::mue_cmd_type    cmd,
   output mue_pkg::mue_status_type status,
   input  logic [7:0]             char_code,
   input  logic                   first_of_message,
   input  logic                   last_of_message,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   unit_on,
   output logic                   last_unit
);

   mue_pkg::mue_char_type pat;

   logic [mue_pkg::SYM_MAX-1:0]    dashes_ff, dashes_in;
   logic [mue_pkg::SYM_CNT_W-1:0]  syms_ff, syms_in;
   logic [mue_pkg::RUN_W-1:0]      run_ff, run_in;
   logic [mue_pkg::UNIT_CNT_W-1:0] count_ff, count_in;
   logic                           pause_ff, pause_in;
   logic                           valid_ff, valid_in;
   logic                           unit_on_ff, unit_on_in;
   logic                           last_unit_ff, last_unit_in;
   logic                           sym_dash;

   assign pat      = mue_pkg::char_lookup(char_code);
   assign sym_dash = cmd.load ? pat.dashes[0] : dashes_ff[1];

   assign status.in_kind   = pat.kind;
   assign status.in_at_cap = !first_of_message && (count_ff == mue_pkg::UNIT_CAP);
   assign status.in_last   = last_of_message;
   assign status.run_zero  = (run_ff == '0);
   assign status.more_syms = (syms_ff > mue_pkg::SYM_CNT_W'(1));
   assign status.pause     = pause_ff;
   assign status.cap_next  = (count_ff == mue_pkg::UNIT_CAP_LAST);
   assign status.out_free  = !valid_ff || rsp_ready;

   always_comb begin
      dashes_in = dashes_ff;
      syms_in   = syms_ff;
      pause_in  = pause_ff;
      count_in  = count_ff;
      run_in    = run_ff;
      if (cmd.load) begin
         dashes_in = pat.dashes;
         syms_in   = pat.len;
         pause_in  = last_of_message;
         if (first_of_message) begin
            count_in = '0;
         end
      end
      if (cmd.sym_next) begin
         dashes_in = dashes_ff >> 1;
         syms_in   = syms_ff - mue_pkg::SYM_CNT_W'(1);
      end
      if (cmd.emit) begin
         count_in = count_ff + mue_pkg::UNIT_CNT_W'(1);
      end
      unique case (cmd.run_op)
         mue_pkg::RUN_HOLD: run_in = run_ff;
         mue_pkg::RUN_DEC:  run_in = run_ff - mue_pkg::RUN_W'(1);
         mue_pkg::RUN_SYM:  run_in = sym_dash ? mue_pkg::DASH_EXTRA : '0;
         mue_pkg::RUN_GAP:  run_in = mue_pkg::GAP_EXTRA;
         mue_pkg::RUN_FOUR: run_in = mue_pkg::FOUR_EXTRA;
         default:           run_in = run_ff;
      endcase
   end

   always_comb begin
      valid_in     = valid_ff && !rsp_ready;
      unit_on_in   = unit_on_ff;
      last_unit_in = last_unit_ff;
      if (cmd.emit) begin
         valid_in     = 1'b1;
         unit_on_in   = cmd.unit_on;
         last_unit_in = cmd.unit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         syms_ff  <= '0;
         run_ff   <= '0;
         count_ff <= '0;
         pause_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         syms_ff  <= syms_in;
         run_ff   <= run_in;
         count_ff <= count_in;
         pause_ff <= pause_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dashes_ff    <= dashes_in;
      unit_on_ff   <= unit_on_in;
      last_unit_ff <= last_unit_in;
   end

   assign rsp_valid = valid_ff;
   assign unit_on   = unit_on_ff;
   assign last_unit = last_unit_ff;

endmodule

// ===== sv/morse_unit_encoder.sv =====
// Morse unit encoder top level: controller, datapath and checks.
//
//  channel   modport  beat payload                                      meaning
//  req_chan  sink     char_code, first_of_message, last_of_message    one message character
//  rsp_chan  source   unit_on, last_unit                              one Morse time unit
//
// A character is accepted and then emits its units, the most for a digit of five dashes
// with the message pause, from the phase sequencer at one unit per cycle while rsp_chan
// is not stalled. A new character is taken once the previous one has its last unit
// in the output register. Reset is synchronous and clears the unit counter.
// A stalled rsp_chan holds its beat and freezes the sequencer in its unit phases.
module morse_unit_encoder (
   input  logic      clock,
   input  logic      reset,
   mue_req_if.sink   req_chan,
   mue_rsp_if.source rsp_chan
);

   mue_pkg::mue_cmd_type    cmd;
   mue_pkg::mue_status_type status;

   mue_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mue_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .char_code        (req_chan.char_code),
      .first_of_message (req_chan.first_of_message),
      .last_of_message  (req_chan.last_of_message),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .unit_on          (rsp_chan.unit_on),
      .last_unit        (rsp_chan.last_unit)
   );

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("unit emitted into a full output register");

   a_cap_marks_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.cap_next) |-> cmd.unit_last)
      else $error("unit reaching the cap not marked last");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.unit_last) |=> !cmd.emit)
      else $error("unit emitted after the last unit of a character");

   a_capped_item_silent: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.in_at_cap) |=> !cmd.emit)
      else $error("unit emitted for a character past the cap");

endmodule
